>>> hw/rtl/mac_address_traffic_stats_table_defines.svh
// Assertion macros for the station statistics table checker.
// Depends on nothing; included by the checker file.
`ifndef MAC_ADDRESS_TRAFFIC_STATS_TABLE_DEFINES_SVH
`define MAC_ADDRESS_TRAFFIC_STATS_TABLE_DEFINES_SVH

// Same-cycle implication under the asynchronous reset.
`define MATS_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("station table assertion failed");

// Next-cycle implication under the asynchronous reset.
`define MATS_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("station table assertion failed");

`endif

>>> hw/rtl/mats_pkg.sv
// Types and constants of the station statistics table.
// No dependencies; imported by every RTL module.
package mats_pkg;

	localparam logic [1:0] KIND_FRAME = 2'd0;
	localparam logic [1:0] KIND_LEARN = 2'd1;
	localparam logic [1:0] KIND_READ  = 2'd2;

	localparam int          GROUP_BIT  = 40;
	localparam logic [47:0] BCAST_ADDR = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_RES,
		ST_WR,
		ST_RD,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [47:0] dest_mac;
		logic [47:0] source_mac;
		logic [16:0] frame_length;
		logic [7:0]  read_index;
	} in_t;

	typedef struct packed {
		logic [7:0]  src_slot;
		logic        src_hit;
		logic [7:0]  dst_slot;
		logic        dst_hit;
		logic [47:0] entry_address;
		logic [63:0] rx_frames;
		logic [63:0] tx_frames;
		logic [63:0] rx_octets;
		logic [63:0] tx_octets;
		logic [63:0] mcast_frames;
		logic [63:0] bcast_frames;
		logic [8:0]  entries_used;
	} out_t;

	typedef struct packed {
		logic [47:0] addr;
		logic [63:0] rxf;
		logic [63:0] txf;
		logic [63:0] rxo;
		logic [63:0] txo;
		logic [63:0] mc;
		logic [63:0] bc;
	} row_t;

endpackage

>>> hw/rtl/mac_address_traffic_stats_table.sv
// Station statistics table top level: search cell row, counter memory, control.
// Depends on mats_pkg, mats_cell and mats_row_ram.
//
// Usage: words enter on in_data under in_valid/in_ready and one result word
// leaves on out_data under out_valid/out_ready for every input word.
// A frame word looks up or adds the source, then the destination, in a row of
// cells that each compare one stored address with the key at once; a learn
// word does the source half only; a read word returns one slot's counters.
// Steps from accept to out_valid: each lookup runs a compare, a resolve and a
// read-modify-write of the counter row (no write on a miss in a full table);
// a frame word does the source, then the destination, a learn word the source
// only, a read word one read state; every kind ends in the output state.
// The next word can be taken from the cycle after the result is registered.
// Reset empties the table at once (the fill count returns to zero; slots at
// or beyond it are never matched or read), so no clearing pass is needed.
// A stalled receiver holds the result in the output register; the block then
// waits in its output state and takes no new word until the register frees.
module mac_address_traffic_stats_table
	import mats_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t           state_q, state_d;
	in_t              req_q;
	logic             phase_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] slot_q;
	logic             alloc_q;
	logic [IDX_W-1:0] s_slot_q, d_slot_q;
	logic             s_hit_q, d_hit_q;
	out_t             out_q;
	logic             out_valid_q;

	logic [47:0]      key;
	logic             hit_chain [TABLE_DEPTH+1];
	logic [IDX_W-1:0] slot_chain [TABLE_DEPTH+1];
	logic             found, room, res_hit, res_alloc, last, out_free;
	logic [IDX_W-1:0] res_slot, ram_rd_addr;
	logic             cell_wr, ram_we;
	row_t             ram_rdata, row_new;
	out_t             result;
	logic [63:0]      len64;

	assign key       = phase_q ? req_q.dest_mac : req_q.source_mac;
	assign found     = hit_chain[TABLE_DEPTH];
	assign room      = count_q < CNT_W'(TABLE_DEPTH);
	assign res_hit   = found | room;
	assign res_alloc = !found && room;
	assign res_slot  = found ? slot_chain[TABLE_DEPTH] : count_q[IDX_W-1:0];
	assign last      = phase_q || (req_q.kind != KIND_FRAME);
	assign out_free  = !out_valid_q || out_ready;
	assign len64     = 64'(req_q.frame_length);

	assign hit_chain[0]  = 1'b0;
	assign slot_chain[0] = '0;

	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		mats_cell #(
			.IDX_W (IDX_W),
			.CNT_W (CNT_W),
			.INDEX (i)
		) u_cell (
			.clk      (clk),
			.wr_en    (cell_wr),
			.wr_slot  (res_slot),
			.key      (key),
			.count    (count_q),
			.hit_in   (hit_chain[i]),
			.slot_in  (slot_chain[i]),
			.hit_out  (hit_chain[i+1]),
			.slot_out (slot_chain[i+1])
		);
	end

	mats_row_ram #(
		.DEPTH (TABLE_DEPTH),
		.IDX_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (slot_q),
		.wr_data (row_new),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (in_data.kind) inside
						KIND_FRAME, KIND_LEARN: state_d = ST_CMP;
						KIND_READ:              state_d = ST_RD;
						default:                state_d = ST_OUT;
					endcase
				end
			end
			ST_CMP: state_d = ST_RES;
			ST_RES: begin
				if (res_hit) begin
					state_d = ST_WR;
				end else if (last) begin
					state_d = ST_OUT;
				end else begin
					state_d = ST_CMP;
				end
			end
			ST_WR:  state_d = last ? ST_OUT : ST_CMP;
			ST_RD:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready    = (state_q == ST_IDLE);
		cell_wr     = (state_q == ST_RES) && res_alloc;
		ram_we      = (state_q == ST_WR);
		ram_rd_addr = (state_q == ST_RES) ? res_slot : IDX_W'(req_q.read_index);
	end

	always_comb begin
		row_new      = alloc_q ? '0 : ram_rdata;
		row_new.addr = key;
		if (req_q.kind == KIND_FRAME) begin
			if (!phase_q) begin
				row_new.txf = row_new.txf + 64'd1;
				row_new.txo = row_new.txo + len64;
			end else begin
				row_new.rxf = row_new.rxf + 64'd1;
				row_new.rxo = row_new.rxo + len64;
				if (key[GROUP_BIT]) begin
					if (key == BCAST_ADDR) begin
						row_new.bc = row_new.bc + 64'd1;
					end else begin
						row_new.mc = row_new.mc + 64'd1;
					end
				end
			end
		end
	end

	always_comb begin
		result              = '0;
		result.src_slot     = 8'(s_slot_q);
		result.src_hit      = s_hit_q;
		result.dst_slot     = 8'(d_slot_q);
		result.dst_hit      = d_hit_q;
		result.entries_used = 9'(count_q);
		if ((req_q.kind == KIND_READ) && (32'(req_q.read_index) < 32'(count_q))) begin
			result.entry_address = ram_rdata.addr;
			result.rx_frames     = ram_rdata.rxf;
			result.tx_frames     = ram_rdata.txf;
			result.rx_octets     = ram_rdata.rxo;
			result.tx_octets     = ram_rdata.txo;
			result.mcast_frames  = ram_rdata.mc;
			result.bcast_frames  = ram_rdata.bc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cell_wr) begin
				count_q <= count_q + CNT_W'(1);
			end
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_q    <= in_data;
			phase_q  <= 1'b0;
			s_slot_q <= '0;
			s_hit_q  <= 1'b0;
			d_slot_q <= '0;
			d_hit_q  <= 1'b0;
		end
		if (state_q == ST_RES) begin
			slot_q  <= res_slot;
			alloc_q <= res_alloc;
			if (!phase_q) begin
				s_slot_q <= res_hit ? res_slot : '0;
				s_hit_q  <= res_hit;
			end else begin
				d_slot_q <= res_hit ? res_slot : '0;
				d_hit_q  <= res_hit;
			end
			if (!res_hit && !last) begin
				phase_q <= 1'b1;
			end
		end
		if ((state_q == ST_WR) && !last) begin
			phase_q <= 1'b1;
		end
		if ((state_q == ST_OUT) && out_free) begin
			out_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/mats_cell.sv
// One search cell: holds one station address and compares it with the key.
// Depends on mats_pkg; chained by the top level.
module mats_cell
	import mats_pkg::*;
#(
	parameter int IDX_W = 8,
	parameter int CNT_W = 9,
	parameter int INDEX = 0
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_slot,
	input  logic [47:0]      key,
	input  logic [CNT_W-1:0] count,
	input  logic             hit_in,
	input  logic [IDX_W-1:0] slot_in,
	output logic             hit_out,
	output logic [IDX_W-1:0] slot_out
);

	logic [47:0] addr_q;
	logic        match_q;

	always_ff @(posedge clk) begin
		if (wr_en && (wr_slot == IDX_W'(INDEX))) begin
			addr_q <= key;
		end
		match_q <= (addr_q == key) && (CNT_W'(INDEX) < count);
	end

	assign hit_out  = hit_in | match_q;
	assign slot_out = slot_in | (match_q ? IDX_W'(INDEX) : '0);

endmodule

>>> hw/rtl/mats_row_ram.sv
// Counter row memory: address copy and six counters per slot.
// Depends on mats_pkg; one write port, one registered read port.
module mats_row_ram
	import mats_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int IDX_W = 8
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  row_t             wr_data,
	input  logic [IDX_W-1:0] rd_addr,
	output row_t             rd_data
);

	row_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> hw/rtl/mats_checker.sv
// Port-level checks of the station statistics table, bound to the top level.
// Depends on mats_pkg and the assertion macro header.
`include "mac_address_traffic_stats_table_defines.svh"

module mats_checker
	import mats_pkg::*;
#(
	parameter int TABLE_DEPTH = 256
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input out_t out_data
);

	`MATS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_data))
	`MATS_ASSERT_IMP(a_fill_bound, clk, arst_n, out_valid,
		32'(out_data.entries_used) <= TABLE_DEPTH)
	`MATS_ASSERT_IMP(a_src_miss_zero, clk, arst_n, out_valid && !out_data.src_hit,
		out_data.src_slot == 8'd0)
	`MATS_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready)

endmodule

bind mac_address_traffic_stats_table mats_checker #(
	.TABLE_DEPTH (TABLE_DEPTH)
) u_mats_checker (.*);

>>> test/tb.sv
// Testbench for the station statistics table: random and directed words, a
// self-contained predictor of the table, and a whole-word result check.
// Depends on mats_pkg and mac_address_traffic_stats_table.
module tb
	import mats_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 256;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	always #10 clk = ~clk;

	mac_address_traffic_stats_table u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
	);

	logic [47:0] st_addr [DEPTH];
	logic [63:0] st_rxf [DEPTH], st_txf [DEPTH], st_rxo [DEPTH], st_txo [DEPTH];
	logic [63:0] st_mc [DEPTH], st_bc [DEPTH];
	int unsigned st_used = 0;

	in_t  pending_words [$];
	out_t expected_results [$];
	int   mismatches = 0;
	int   results_seen = 0;
	int   words_sent = 0;
	int   idle_cycles = 0;
	bit   quiet = 0;
	int   tx_idle = 0;
	int   rx_hold = 0;
	bit   rx_stall = 0;
	bit   timed_out = 0;

	function automatic bit find_or_add(input logic [47:0] a, output logic [7:0] slot);
		int i;
		slot = '0;
		for (i = 0; i < st_used; i++)
			if (st_addr[i] == a) begin
				slot = i[7:0];
				return 1;
			end
		if (st_used < DEPTH) begin
			st_addr[st_used] = a;
			st_rxf[st_used] = 0; st_txf[st_used] = 0;
			st_rxo[st_used] = 0; st_txo[st_used] = 0;
			st_mc[st_used] = 0; st_bc[st_used] = 0;
			slot = st_used[7:0];
			st_used++;
			return 1;
		end
		return 0;
	endfunction

	function automatic out_t predict_stats(input in_t w);
		out_t r;
		logic [7:0] s;
		r = '0;
		if (w.kind == KIND_FRAME) begin
			r.src_hit = find_or_add(w.source_mac, s);
			r.src_slot = s;
			if (r.src_hit) begin
				st_txf[s] += 64'd1;
				st_txo[s] += 64'(w.frame_length);
			end
			r.dst_hit = find_or_add(w.dest_mac, s);
			r.dst_slot = s;
			if (r.dst_hit) begin
				st_rxf[s] += 64'd1;
				st_rxo[s] += 64'(w.frame_length);
				if (w.dest_mac[GROUP_BIT]) begin
					if (w.dest_mac == BCAST_ADDR) st_bc[s] += 64'd1;
					else st_mc[s] += 64'd1;
				end
			end
		end else if (w.kind == KIND_LEARN) begin
			r.src_hit = find_or_add(w.source_mac, s);
			r.src_slot = s;
		end else if (w.kind == KIND_READ) begin
			if (w.read_index < st_used) begin
				r.entry_address = st_addr[w.read_index];
				r.rx_frames = st_rxf[w.read_index];
				r.tx_frames = st_txf[w.read_index];
				r.rx_octets = st_rxo[w.read_index];
				r.tx_octets = st_txo[w.read_index];
				r.mcast_frames = st_mc[w.read_index];
				r.bcast_frames = st_bc[w.read_index];
			end
		end
		r.entries_used = st_used[8:0];
		return r;
	endfunction

	// A small address pool makes frames revisit known stations.
	logic [47:0] station_pool [16];

	function automatic logic [47:0] pick_addr();
		int c;
		c = $urandom_range(0, 9);
		if (c < 6) return station_pool[$urandom_range(0, 15)];
		if (c == 6) return BCAST_ADDR;
		if (c == 7) return {8'h01, 8'h00, 8'h5e, 24'($urandom)};
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic in_t make_word(input logic [1:0] k, input logic [47:0] d,
		input logic [47:0] s, input logic [16:0] len, input logic [7:0] idx);
		in_t w;
		w.kind = k; w.dest_mac = d; w.source_mac = s;
		w.frame_length = len; w.read_index = idx;
		return w;
	endfunction

	function automatic in_t random_word();
		int c;
		logic [16:0] len;
		c = $urandom_range(0, 19);
		len = ($urandom_range(0, 9) == 0) ? 17'($urandom) : 17'($urandom_range(1, 1518));
		if (c < 11) return make_word(KIND_FRAME, pick_addr(), pick_addr(), len, 8'($urandom));
		if (c < 14) return make_word(KIND_LEARN, 48'($urandom), pick_addr(), len, 8'($urandom));
		if (c < 19) return make_word(KIND_READ, {16'($urandom), 32'($urandom)},
			{16'($urandom), 32'($urandom)}, len, 8'($urandom_range(0, st_used + 3)));
		return make_word(2'd3, pick_addr(), pick_addr(), len, 8'($urandom));
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_stats(in_data));
				words_sent++;
			end
			if (!(in_valid && !in_ready)) begin
				if (tx_idle > 0) begin
					tx_idle <= tx_idle - 1;
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0 && !quiet &&
						$urandom_range(0, 3) == 0) begin
					tx_idle <= $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else if (pending_words.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= pending_words.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("tb: unexpected result word %h", out_data);
				end else begin
					out_t e;
					e = expected_results.pop_front();
					if (e !== out_data) begin
						mismatches++;
						if (mismatches <= 10)
							$display("tb: mismatch\n  expected %h\n  actual   %h", e, out_data);
					end
				end
			end
			if (rx_stall) begin
				out_ready <= 1'b0;
			end else if (rx_hold > 0) begin
				rx_hold <= rx_hold - 1;
				out_ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 9) == 0) begin
				rx_hold <= $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
			if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
		end
	end

	always @(posedge clk)
		if (idle_cycles >= WATCHDOG && !timed_out) begin
			timed_out = 1;
			$display("tb: done, errors");
			$finish;
		end

	task automatic wait_drained();
		while (pending_words.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	initial begin
		int i;
		for (i = 0; i < 16; i++) station_pool[i] = {8'($urandom) & 8'hfe, 8'($urandom), 32'($urandom)};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: unoccupied read, extremes, same station, group addresses, unused kind.
		pending_words.push_back(make_word(KIND_READ, '0, '0, 17'd1, 8'd0));
		pending_words.push_back(make_word(KIND_FRAME, '1, '0, 17'd1, 8'hff));
		pending_words.push_back(make_word(KIND_FRAME, '0, '1, 17'h1ffff, 8'd0));
		pending_words.push_back(make_word(KIND_FRAME, 48'h0100_5e00_0001, 48'h0200_0000_0001,
			17'd64, 8'd0));
		pending_words.push_back(make_word(KIND_FRAME, 48'h0200_0000_0001, 48'h0200_0000_0001,
			17'd0, 8'd0));
		pending_words.push_back(make_word(KIND_LEARN, '0, 48'h0200_0000_0001, 17'd5, 8'd0));
		pending_words.push_back(make_word(KIND_LEARN, '1, 48'h1234_5678_9abc, 17'd5, 8'd0));
		pending_words.push_back(make_word(2'd3, '1, '1, 17'h1ffff, 8'hff));
		for (i = 0; i < 7; i++)
			pending_words.push_back(make_word(KIND_READ, '1, '1, 17'h1ffff, i[7:0]));
		pending_words.push_back(make_word(KIND_READ, '0, '0, 17'd1, 8'hff));
		wait_drained();

		// Receiver holds off long while the sender keeps offering words.
		fork
			begin
				rx_stall <= 1'b1;
				repeat (300) @(posedge clk);
				rx_stall <= 1'b0;
			end
		join_none
		for (i = 0; i < 20; i++) pending_words.push_back(random_word());
		wait_drained();

		for (i = 0; i < 330; i++) pending_words.push_back(random_word());
		wait_drained();

		// Fill the table to its end with fresh stations, then hit it full.
		while (st_used + pending_words.size() < DEPTH + 4)
			pending_words.push_back(make_word(KIND_LEARN, '0,
				{16'hfe00 | 16'($urandom), 32'($urandom)}, 17'd1, 8'd0));
		wait_drained();
		for (i = 0; i < 220; i++) pending_words.push_back(random_word());
		for (i = 0; i < 8; i++)
			pending_words.push_back(make_word(KIND_READ, '0, '0, 17'd1, 8'(248 + i)));
		wait_drained();

		quiet = 1;
		for (i = 0; i < 50; i++) pending_words.push_back(random_word());
		wait_drained();

		$display("tb: %0d words sent, %0d results checked, table filled to %0d slots",
			words_sent, results_seen, st_used);
		if (mismatches == 0) $display("tb: done, clean");
		else $display("tb: done, errors");
		$finish;
	end
endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/mats_pkg.sv
hw/rtl/mats_cell.sv
hw/rtl/mats_row_ram.sv
hw/rtl/mac_address_traffic_stats_table.sv
hw/rtl/mats_checker.sv
test/tb.sv
